>>> hw/rtl/gprhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gprhc_pkg
// Shared types and constants for the glow plug ramp-and-hold controller.
// ----------------------------------------------------------------------------
package gprhc_pkg;

    // Field and register widths
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned PHASE_W     = 2;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_HOLD_TICKS = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_MAX_ON_TICKS    = 16'd50;
    localparam logic [CFG_W-1:0] RST_OFF_TICKS       = 16'd100;
    localparam logic [CFG_W-1:0] RST_RAMP_HOLD_TICKS = 16'd10;

    // Reported operating phase
    typedef enum logic [PHASE_W-1:0] {
        PHASE_RAMP     = 2'd0,
        PHASE_HOLD_OFF = 2'd1,
        PHASE_HOLD_ON  = 2'd2
    } t_phase;

endpackage

>>> hw/rtl/glow_plug_ramp_and_hold_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glow_plug_ramp_and_hold_controller_top
// Ramp-and-hold igniter drive: tick-counted PWM with a stepped duty until the
// igniter reports hot, then a forced-off / on hold cycle.
// ----------------------------------------------------------------------------
// Each transfer on the slave stream is one control tick and produces exactly
// one result transfer on the master stream. The block takes one tick per
// clock cycle while the result stream does not back-pressure; a tick's result
// is offered once the tick has passed the input register and one pass of
// counter logic has loaded the result register, and the result register lets
// the next tick enter while a result still waits.
// The per-tick state update is a single registered pass, which sets that
// rate. Configuration writes are taken in any cycle (o_cfg_ready is always
// high) and should only be issued while no tick is in flight. COUNT_WIDTH
// sets the width of the saturating step timer.
// ----------------------------------------------------------------------------
module glow_plug_ramp_and_hold_controller_top
    import gprhc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Tick input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [0] heated, [7:1] zero
    // Result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // [0] heater_on, [2:1] phase,
                                                 // [18:3] on_ticks, [23:19] zero
);

    localparam int unsigned POS_W = CFG_W + 1;
    localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    // Configuration registers
    logic [CFG_W-1:0] r_max_on_ticks;
    logic [CFG_W-1:0] r_off_ticks;
    logic [CFG_W-1:0] r_ramp_hold_ticks;

    // Controller state
    logic                   r_hold_phase,  n_hold_phase;
    logic                   r_ramp_frozen, n_ramp_frozen;
    logic                   r_forced_off,  n_forced_off;
    logic [CFG_W-1:0]       r_duty_count,  n_duty_count;
    logic [POS_W-1:0]       r_pwm_position, n_pwm_position;
    logic [POS_W-1:0]       r_off_counter, n_off_counter;
    logic [COUNT_WIDTH-1:0] r_since_step,  n_since_step;
    logic                   r_drive_level, n_drive_level;

    // Pipeline registers
    logic                   r_in_valid;
    logic                   r_heated;
    logic                   r_out_valid;
    logic                   r_out_heater_on;
    t_phase                 r_out_phase, n_phase;
    logic [CFG_W-1:0]       r_out_on_ticks;

    logic                   w_advance;
    logic [POS_W-1:0]       w_duty_inc;

    // Handshakes: move a tick forward when the result slot is free or draining
    assign o_cfg_ready   = 1'b1;
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_duty_inc    = {1'b0, r_duty_count} + POS_W'(1);

    // Next state for one tick
    always_comb begin
        n_hold_phase   = r_hold_phase;
        n_ramp_frozen  = r_ramp_frozen;
        n_forced_off   = r_forced_off;
        n_duty_count   = r_duty_count;
        n_pwm_position = r_pwm_position;
        n_off_counter  = r_off_counter;
        n_drive_level  = r_drive_level;
        n_since_step   = r_since_step;

        // Advance the step timer, saturating at full scale
        if (r_since_step != {COUNT_WIDTH{1'b1}}) begin
            n_since_step = r_since_step + COUNT_WIDTH'(1);
        end

        if (!r_hold_phase) begin
            // Step the duty and restart the step timer
            if (!r_ramp_frozen) begin
                n_since_step  = '0;
                n_duty_count  = (w_duty_inc > {1'b0, r_max_on_ticks}) ?
                                r_max_on_ticks : w_duty_inc[CFG_W-1:0];
                n_ramp_frozen = 1'b1;
            end
            if (CMP_W'(n_since_step) > CMP_W'(r_ramp_hold_ticks)) begin
                n_ramp_frozen = 1'b0;
            end

            // Run the PWM period
            if (r_pwm_position < {1'b0, n_duty_count}) begin
                n_drive_level  = 1'b1;
                n_pwm_position = r_pwm_position + POS_W'(1);
            end else if (r_pwm_position <= {1'b0, r_off_ticks}) begin
                n_drive_level  = 1'b0;
                n_pwm_position = r_pwm_position + POS_W'(1);
                if (n_pwm_position > {1'b0, r_off_ticks}) begin
                    n_pwm_position = '0;
                end
            end else begin
                n_pwm_position = '0;
            end

            // Igniter hot: enter hold phase with drive forced off
            if (r_heated) begin
                n_hold_phase   = 1'b1;
                n_ramp_frozen  = 1'b0;
                n_duty_count   = '0;
                n_pwm_position = '0;
                n_drive_level  = 1'b0;
                n_forced_off   = 1'b1;
            end
        end else if (!r_forced_off) begin
            // Drive on until hot again
            if (r_heated) begin
                n_drive_level = 1'b0;
                n_forced_off  = 1'b1;
                n_off_counter = r_off_counter + POS_W'(1);
            end
        end else begin
            // Count the forced-off time
            n_off_counter = r_off_counter + POS_W'(1);
            if (n_off_counter > {1'b0, r_off_ticks}) begin
                n_drive_level = 1'b1;
                n_forced_off  = 1'b0;
                n_off_counter = '0;
            end
        end
    end

    // Reported phase
    always_comb begin
        if (!n_hold_phase) begin
            n_phase = PHASE_RAMP;
        end else if (n_forced_off) begin
            n_phase = PHASE_HOLD_OFF;
        end else begin
            n_phase = PHASE_HOLD_ON;
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_on_ticks    <= RST_MAX_ON_TICKS;
            r_off_ticks       <= RST_OFF_TICKS;
            r_ramp_hold_ticks <= RST_RAMP_HOLD_TICKS;
            r_hold_phase      <= 1'b0;
            r_ramp_frozen     <= 1'b0;
            r_forced_off      <= 1'b0;
            r_duty_count      <= '0;
            r_pwm_position    <= '0;
            r_off_counter     <= '0;
            r_since_step      <= '0;
            r_drive_level     <= 1'b0;
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            // Take configuration writes; ignore unused indexes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_ON_TICKS:    r_max_on_ticks    <= i_cfg_data;
                    CFG_OFF_TICKS:       r_off_ticks       <= i_cfg_data;
                    CFG_RAMP_HOLD_TICKS: r_ramp_hold_ticks <= i_cfg_data;
                    default: ;
                endcase
            end

            // Commit one tick
            if (w_advance) begin
                r_hold_phase   <= n_hold_phase;
                r_ramp_frozen  <= n_ramp_frozen;
                r_forced_off   <= n_forced_off;
                r_duty_count   <= n_duty_count;
                r_pwm_position <= n_pwm_position;
                r_off_counter  <= n_off_counter;
                r_since_step   <= n_since_step;
                r_drive_level  <= n_drive_level;
            end

            // Input slot occupancy
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            // Result slot occupancy
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_heated <= s_axis_tdata[0];
        end
        if (w_advance) begin
            r_out_heater_on <= n_drive_level;
            r_out_phase     <= n_phase;
            r_out_on_ticks  <= n_duty_count;
        end
    end

    // Pack the result
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_on_ticks, r_out_phase, r_out_heater_on};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Hold phase is never left once entered
    a_hold_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_phase |=> r_hold_phase)
        else $error("hold phase dropped back to ramp");

    // In hold phase the ramp duty reads zero
    a_hold_duty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_phase != PHASE_RAMP)) |-> (r_out_on_ticks == '0))
        else $error("nonzero on_ticks reported in hold phase");

    // Forced-off phase never reports the drive on
    a_forced_off_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_phase == PHASE_HOLD_OFF)) |-> !r_out_heater_on)
        else $error("drive on during forced-off time");

    // Input stalls only while a tick is waiting in the input register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a blocked tick");

endmodule
